// ===== hw/rtl/wsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfe_pkg
// Types, constants and header byte functions for the WebSocket frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfe_pkg;

  localparam logic [7:0]  FIN_BIT    = 8'h80;
  localparam logic [7:0]  MASK_BIT   = 8'h80;
  localparam logic [31:0] LEN7_MAX   = 32'd125;
  localparam logic [31:0] LEN16_MAX  = 32'h0000_FFFF;
  localparam logic [6:0]  LEN16_CODE = 7'd126;
  localparam logic [6:0]  LEN64_CODE = 7'd127;
  localparam int          HDR_IDX_W  = 4;

  typedef enum logic [1:0] {
    HDR_SHORT,
    HDR_MID,
    HDR_LONG
  } hdr_cls_t;

  // One queued command: a whole header or one finished payload word
  typedef struct packed {
    logic        is_hdr;
    hdr_cls_t    cls;
    logic [3:0]  opcode;
    logic [31:0] len;
    logic [31:0] key;
    logic [7:0]  dbyte;
    logic        fend;
    logic        stray;
  } cmd_t;

  function automatic logic [HDR_IDX_W-1:0] hdr_last_idx(input hdr_cls_t cls);
    logic [HDR_IDX_W-1:0] r;
    case (cls)
      HDR_SHORT: r = HDR_IDX_W'(5);
      HDR_MID:   r = HDR_IDX_W'(7);
      HDR_LONG:  r = HDR_IDX_W'(13);
      default:   r = HDR_IDX_W'(5);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] sel);
    return key[8*sel +: 8];
  endfunction

  function automatic logic [7:0] hdr_byte(input cmd_t c, input logic [HDR_IDX_W-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx == '0) begin
      b = FIN_BIT | {4'h0, c.opcode};
    end else begin
      case (c.cls)
        HDR_SHORT: begin
          if (idx == HDR_IDX_W'(1)) b = MASK_BIT | {1'b0, c.len[6:0]};
          else                      b = key_byte(c.key, idx[1:0] - 2'd2);
        end
        HDR_MID: begin
          case (idx)
            HDR_IDX_W'(1): b = MASK_BIT | {1'b0, LEN16_CODE};
            HDR_IDX_W'(2): b = c.len[15:8];
            HDR_IDX_W'(3): b = c.len[7:0];
            default:       b = key_byte(c.key, idx[1:0]);
          endcase
        end
        HDR_LONG: begin
          case (idx)
            HDR_IDX_W'(1): b = MASK_BIT | {1'b0, LEN64_CODE};
            HDR_IDX_W'(2),
            HDR_IDX_W'(3),
            HDR_IDX_W'(4),
            HDR_IDX_W'(5): b = 8'h00;
            HDR_IDX_W'(6): b = c.len[31:24];
            HDR_IDX_W'(7): b = c.len[23:16];
            HDR_IDX_W'(8): b = c.len[15:8];
            HDR_IDX_W'(9): b = c.len[7:0];
            default:       b = key_byte(c.key, idx[1:0] - 2'd2);
          endcase
        end
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wsfe_in_if.sv =====
// ----------------------------------------------------------------------------
// wsfe_in_if
// Input channel: start items and payload words with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsfe_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [3:0]  opcode;
  logic [31:0] payload_length;
  logic [31:0] mask_key;
  logic [7:0]  data_byte;

  modport source (output valid, mode, opcode, payload_length, mask_key, data_byte,
                  input ready);
  modport sink   (input valid, mode, opcode, payload_length, mask_key, data_byte,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wsfe_out_if.sv =====
// ----------------------------------------------------------------------------
// wsfe_out_if
// Output channel: wire bytes of the frame with flags, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_header;
  logic       run_last;
  logic       frame_end;
  logic       stray_error;

  modport source (output valid, out_byte, is_header, run_last, frame_end, stray_error,
                  input ready);
  modport sink   (input valid, out_byte, is_header, run_last, frame_end, stray_error,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wsfe_front.sv =====
// ----------------------------------------------------------------------------
// wsfe_front
// Accepts input words, tracks frame state and pushes decoded commands.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfe_front (
  input  wire logic          clk,
  input  wire logic          rst,
  wsfe_in_if.sink            item,
  output wsfe_pkg::cmd_t     push_cmd,
  output logic               push_valid,
  input  wire logic          push_ready
);

  logic [31:0] remaining;
  logic [31:0] key;
  logic [1:0]  phase;
  logic        accept;
  logic        rem_zero;

  assign item.ready = push_ready;
  assign push_valid = item.valid;
  assign accept     = item.valid && push_ready;
  assign rem_zero   = (remaining == '0);

  always_comb begin
    push_cmd        = '0;
    push_cmd.opcode = item.opcode;
    push_cmd.len    = item.payload_length;
    push_cmd.key    = item.mask_key;
    if (!item.mode) begin
      push_cmd.is_hdr = 1'b1;
      if (item.payload_length <= wsfe_pkg::LEN7_MAX)       push_cmd.cls = wsfe_pkg::HDR_SHORT;
      else if (item.payload_length <= wsfe_pkg::LEN16_MAX) push_cmd.cls = wsfe_pkg::HDR_MID;
      else                                                 push_cmd.cls = wsfe_pkg::HDR_LONG;
      push_cmd.fend = (item.payload_length == '0);
    end else if (rem_zero) begin
      // no open frame: flag and drop
      push_cmd.stray = 1'b1;
    end else begin
      push_cmd.dbyte = item.data_byte ^ wsfe_pkg::key_byte(key, phase);
      push_cmd.fend  = (remaining == 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      key       <= '0;
      phase     <= '0;
    end else if (accept) begin
      if (!item.mode) begin
        remaining <= item.payload_length;
        key       <= item.mask_key;
        phase     <= '0;
      end else if (!rem_zero) begin
        remaining <= remaining - 32'd1;
        phase     <= phase + 2'd1;
      end
    end
  end

  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    accept && !item.mode |=> phase == '0 && remaining == $past(item.payload_length))
    else $error("frame state not reloaded on start");

  a_payload_counts: assert property (@(posedge clk) disable iff (rst)
    accept && item.mode && !rem_zero |=> remaining == $past(remaining) - 32'd1)
    else $error("remaining count did not step on payload word");

endmodule

`default_nettype wire

// ===== hw/rtl/wsfe_fifo.sv =====
// ----------------------------------------------------------------------------
// wsfe_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfe_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire wsfe_pkg::cmd_t push_cmd,
  input  wire logic           push_valid,
  output logic                push_ready,
  output wsfe_pkg::cmd_t      pop_cmd,
  output logic                pop_valid,
  input  wire logic           pop_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsfe_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (!do_push && do_pop) count <= count - CW'(1);
    end
  end

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count != '0)
    else $error("queue empty right after a push");

endmodule

`default_nettype wire

// ===== hw/rtl/wsfe_back.sv =====
// ----------------------------------------------------------------------------
// wsfe_back
// Sequences header bytes and passes payload words to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfe_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire wsfe_pkg::cmd_t pop_cmd,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  wsfe_out_if.source          result
);

  logic [wsfe_pkg::HDR_IDX_W-1:0] idx;
  logic [wsfe_pkg::HDR_IDX_W-1:0] last_idx;
  logic                           adv;
  logic                           at_last;
  logic                           out_valid;
  logic [7:0]                     out_byte;
  logic                           is_header;
  logic                           run_last;
  logic                           frame_end;
  logic                           stray_error;

  assign last_idx = wsfe_pkg::hdr_last_idx(pop_cmd.cls);
  assign at_last  = (idx == last_idx);
  assign adv      = !out_valid || result.ready;
  // pop a header only once its last byte is loaded
  assign pop_ready = adv && pop_valid && (!pop_cmd.is_hdr || at_last);

  assign result.valid       = out_valid;
  assign result.out_byte    = out_byte;
  assign result.is_header   = is_header;
  assign result.run_last    = run_last;
  assign result.frame_end   = frame_end;
  assign result.stray_error = stray_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (adv) begin
      out_valid <= pop_valid;
      if (pop_valid && pop_cmd.is_hdr) idx <= at_last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pop_valid) begin
      if (pop_cmd.is_hdr) begin
        out_byte  <= wsfe_pkg::hdr_byte(pop_cmd, idx);
        run_last  <= at_last;
        frame_end <= at_last && pop_cmd.fend;
      end else begin
        out_byte  <= pop_cmd.dbyte;
        run_last  <= 1'b1;
        frame_end <= pop_cmd.fend;
      end
      is_header   <= pop_cmd.is_hdr;
      stray_error <= pop_cmd.stray;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    pop_valid && pop_cmd.is_hdr |-> idx <= last_idx)
    else $error("header byte index past end of header");

  a_pop_shows: assert property (@(posedge clk) disable iff (rst)
    pop_valid && pop_ready |=> result.valid && result.run_last)
    else $error("popped command did not end its run on the output");

endmodule

`default_nettype wire

// ===== hw/rtl/websocket_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_encoder
// Client WebSocket frame builder with payload masking.
//
//   channel   dir  fields
//   item      in   mode, opcode, payload_length, mask_key, data_byte
//   result    out  out_byte, is_header, run_last, frame_end, stray_error
//
// Payload words stream at one per clock unless the output or a header stalls.
// A start word yields 6, 8 or 14 header bytes, one per cycle while the output
// is ready, set by the header byte sequencer in the back part; the queue keeps
// accepting meanwhile until full. Words pass the queue to the output register.
// rst is synchronous and clears frame state, queue and output valid.
// Either side may stall; the queue and the output register hold their words.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_encoder #(
  parameter int FIFO_DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  wsfe_in_if.sink    item,
  wsfe_out_if.source result
);

  wsfe_pkg::cmd_t push_cmd;
  wsfe_pkg::cmd_t pop_cmd;
  logic           push_valid;
  logic           push_ready;
  logic           pop_valid;
  logic           pop_ready;

  wsfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  wsfe_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  wsfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== tb/sv/websocket_frame_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_encoder_tb
// Drives start and payload words into the frame encoder under random valid
// and ready gaps, predicts every header and masked payload byte with its
// flags, and checks each output word in order against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module websocket_frame_encoder_tb;

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_PAYLOAD = 1'b1;
  localparam int   STALL_LIMIT  = 2000;
  localparam int   TAIL_CYCLES  = 20;
  localparam int   HOLD_CYCLES  = 64;
  localparam int   MAX_PRINTS   = 50;

  typedef struct packed {
    logic        mode;
    logic [3:0]  opcode;
    logic [31:0] plen;
    logic [31:0] key;
    logic [7:0]  data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       hdr;
    logic       last;
    logic       fend;
    logic       stray;
  } wire_word_t;

  logic clk;
  logic rst;

  wsfe_in_if  item_if ();
  wsfe_out_if result_if ();

  websocket_frame_encoder u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  in_word_t   word_queue[$];
  wire_word_t expected_bytes[$];
  in_word_t   cur_word;
  logic       word_taken;
  int         pushed_cnt;
  int         accepted_cnt;
  int         err_count;
  int         stall_cycles;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         phase;
  logic       hold_rx;

  // frame state of the predictor
  logic [31:0] remaining_len;
  logic [31:0] frame_key;
  logic [1:0]  key_idx;

  always #6 clk = ~clk;

  task automatic log_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_PRINTS)
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic encode_word(input in_word_t w);
    logic [7:0] hb[$];
    wire_word_t e;
    int i;
    if (w.mode == MODE_START) begin
      hb.push_back(wsfe_pkg::FIN_BIT | {4'h0, w.opcode});
      if (w.plen <= wsfe_pkg::LEN7_MAX) begin
        hb.push_back(wsfe_pkg::MASK_BIT | w.plen[7:0]);
      end else if (w.plen <= wsfe_pkg::LEN16_MAX) begin
        hb.push_back(wsfe_pkg::MASK_BIT | {1'b0, wsfe_pkg::LEN16_CODE});
        hb.push_back(w.plen[15:8]);
        hb.push_back(w.plen[7:0]);
      end else begin
        hb.push_back(wsfe_pkg::MASK_BIT | {1'b0, wsfe_pkg::LEN64_CODE});
        for (i = 0; i < 4; i++) hb.push_back(8'h00);
        for (i = 3; i >= 0; i--) hb.push_back(w.plen[8*i +: 8]);
      end
      for (i = 0; i < 4; i++) hb.push_back(w.key[8*i +: 8]);
      for (i = 0; i < hb.size(); i++) begin
        e.wire_byte = hb[i];
        e.hdr       = 1'b1;
        e.last      = (i == hb.size() - 1);
        e.fend      = e.last && (w.plen == 32'd0);
        e.stray     = 1'b0;
        expected_bytes.push_back(e);
      end
      // a start abandons any open frame
      remaining_len = w.plen;
      frame_key     = w.key;
      key_idx       = 2'd0;
    end else if (remaining_len == 32'd0) begin
      e = '{wire_byte: 8'h00, hdr: 1'b0, last: 1'b1, fend: 1'b0, stray: 1'b1};
      expected_bytes.push_back(e);
    end else begin
      e.wire_byte   = w.data ^ frame_key[8*key_idx +: 8];
      remaining_len = remaining_len - 32'd1;
      key_idx       = key_idx + 2'd1;
      e.hdr         = 1'b0;
      e.last        = 1'b1;
      e.fend        = (remaining_len == 32'd0);
      e.stray       = 1'b0;
      expected_bytes.push_back(e);
    end
  endtask

  function automatic in_word_t start_word(input logic [3:0] op, input logic [31:0] len,
                                          input logic [31:0] key);
    in_word_t w;
    w.mode   = MODE_START;
    w.opcode = op;
    w.plen   = len;
    w.key    = key;
    w.data   = 8'($urandom);
    return w;
  endfunction

  function automatic in_word_t payload_word(input logic [7:0] d);
    in_word_t w;
    w.mode   = MODE_PAYLOAD;
    w.opcode = 4'($urandom);
    w.plen   = $urandom;
    w.key    = $urandom;
    w.data   = d;
    return w;
  endfunction

  task automatic offer(input in_word_t w);
    word_queue.push_back(w);
    pushed_cnt++;
  endtask

  task automatic offer_payload(input int n);
    int i;
    for (i = 0; i < n; i++) offer(payload_word(8'($urandom)));
  endtask

  // mostly complete frames; the rest are abandoned frames and stray bytes
  task automatic queue_random_frames(input int count);
    int goal;
    int kind;
    int len;
    goal = pushed_cnt + count;
    while (pushed_cnt < goal) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        len = $urandom_range(9);
        offer(start_word(4'($urandom), 32'(len), $urandom));
        offer_payload(len);
        if ($urandom_range(99) < 20) offer(payload_word(8'($urandom)));
      end else if (kind < 72) begin
        offer(start_word(4'($urandom), $urandom_range(32'hFFFF, 126), $urandom));
        offer_payload($urandom_range(3));
      end else if (kind < 84) begin
        offer(start_word(4'($urandom), $urandom_range(32'hFFFF_FFFF, 32'h1_0000),
                         $urandom));
        offer_payload($urandom_range(3));
      end else if (kind < 93) begin
        offer(start_word(4'($urandom), $urandom_range(125, 10), $urandom));
        offer_payload($urandom_range(5));
      end else begin
        offer(payload_word(8'($urandom)));
      end
    end
  endtask

  // input driver: hold the word until it is taken
  always @(negedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
    end else if (!item_if.valid || word_taken) begin
      if (word_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        cur_word = word_queue.pop_front();
        item_if.valid          <= 1'b1;
        item_if.mode           <= cur_word.mode;
        item_if.opcode         <= cur_word.opcode;
        item_if.payload_length <= cur_word.plen;
        item_if.mask_key       <= cur_word.key;
        item_if.data_byte      <= cur_word.data;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
    word_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (rst || hold_rx)
      result_if.ready <= 1'b0;
    else
      result_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : mon
    wire_word_t want;
    if (!rst) begin
      if (item_if.valid && item_if.ready) begin
        encode_word(cur_word);
        word_taken = 1'b1;
        accepted_cnt++;
      end
      if (result_if.valid && result_if.ready) begin
        if (expected_bytes.size() == 0) begin
          log_mismatch("unexpected word", result_if.out_byte, 0);
        end else begin
          want = expected_bytes.pop_front();
          if (result_if.out_byte !== want.wire_byte)
            log_mismatch("out_byte", result_if.out_byte, want.wire_byte);
          if (result_if.is_header !== want.hdr)
            log_mismatch("is_header", result_if.is_header, want.hdr);
          if (result_if.run_last !== want.last)
            log_mismatch("run_last", result_if.run_last, want.last);
          if (result_if.frame_end !== want.fend)
            log_mismatch("frame_end", result_if.frame_end, want.fend);
          if (result_if.stray_error !== want.stray)
            log_mismatch("stray_error", result_if.stray_error, want.stray);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // long receiver hold-off once both sides run flat out
  initial begin
    hold_rx = 1'b0;
    wait (phase == 2);
    repeat (4) @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    item_if.valid          = 1'b0;
    item_if.mode           = MODE_START;
    item_if.opcode         = '0;
    item_if.payload_length = '0;
    item_if.mask_key       = '0;
    item_if.data_byte      = '0;
    result_if.ready        = 1'b0;
    word_taken    = 1'b0;
    pushed_cnt    = 0;
    accepted_cnt  = 0;
    err_count     = 0;
    stall_cycles  = 0;
    remaining_len = '0;
    frame_key     = '0;
    key_idx       = '0;
    phase         = 0;
    tx_idle_pct   = 14;
    rx_idle_pct   = 70;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // stray byte straight after reset, an empty frame, a one-byte frame, a stray byte
    offer(payload_word(8'hFF));
    offer(start_word(4'h0, 32'd0, 32'hFFFF_FFFF));
    offer(start_word(4'hF, 32'd1, 32'h1234_5678));
    offer(payload_word(8'hA5));
    offer(payload_word(8'h3C));
    // each length form, abandoned part way by the next start
    offer(start_word(4'h1, wsfe_pkg::LEN7_MAX, 32'hA5A5_A5A5));
    offer_payload(2);
    offer(start_word(4'h2, 32'd126, 32'h0000_0000));
    offer_payload(2);
    offer(start_word(4'h8, wsfe_pkg::LEN16_MAX, 32'h8001_0080));
    offer_payload(1);
    offer(start_word(4'hA, 32'h1_0000, 32'h7F7F_7F7F));
    offer_payload(1);
    offer(start_word(4'h2, 32'hFFFF_FFFF, 32'h0000_0000));
    offer(payload_word(8'h00));
    offer(payload_word(8'hFF));
    // full frame across one key wrap, then a stray byte
    offer(start_word(4'h9, 32'd4, 32'hDEAD_BEEF));
    offer(payload_word(8'h00));
    offer(payload_word(8'hFF));
    offer(payload_word(8'h5A));
    offer(payload_word(8'hA5));
    offer(payload_word(8'h81));
    queue_random_frames(50);
    wait (accepted_cnt == pushed_cnt);

    phase       = 1;
    tx_idle_pct = 70;
    rx_idle_pct = 14;
    queue_random_frames(50);
    wait (accepted_cnt == pushed_cnt);

    phase       = 2;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_frames(50);
    wait (accepted_cnt == pushed_cnt);

    wait (expected_bytes.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/wsfe_pkg.sv
hw/rtl/wsfe_in_if.sv
hw/rtl/wsfe_out_if.sv
hw/rtl/wsfe_front.sv
hw/rtl/wsfe_fifo.sv
hw/rtl/wsfe_back.sv
hw/rtl/websocket_frame_encoder.sv
tb/sv/websocket_frame_encoder_tb.sv
